// ----- sv/tlds_pkg.sv -----
// ============================================================================
// Delimiter splitter package
// Shared widths, codes and request types for the top-level delimiter splitter.
// ============================================================================
`default_nettype none

package tlds_pkg;

    // Sizing of the bracket stack and of the text positions.
    localparam int STACK_DEPTH = 32;
    localparam int POS_BITS    = 16;
    localparam int LEVEL_BITS  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_BITS    = $clog2(STACK_DEPTH);
    localparam int MASK_BITS   = 10;

    // Bit positions in the split enable mask.
    localparam int MASK_BRK0     = 0;
    localparam int MASK_BRK1     = 1;
    localparam int MASK_BRK2     = 2;
    localparam int MASK_COMMA    = 3;
    localparam int MASK_SEMI     = 4;
    localparam int MASK_ASSIGN   = 5;
    localparam int MASK_LAMBDA   = 6;
    localparam int MASK_QUESTION = 7;
    localparam int MASK_NULLCOAL = 8;
    localparam int MASK_COLON    = 9;

    // Token classes delivered by the lexer.
    typedef enum logic [3:0] {
        TK_OTHER    = 4'd0,
        TK_OPEN0    = 4'd1,
        TK_OPEN1    = 4'd2,
        TK_OPEN2    = 4'd3,
        TK_CLOSE0   = 4'd4,
        TK_CLOSE1   = 4'd5,
        TK_CLOSE2   = 4'd6,
        TK_COMMA    = 4'd7,
        TK_SEMI     = 4'd8,
        TK_ASSIGN   = 4'd9,
        TK_LAMBDA   = 4'd10,
        TK_QUESTION = 4'd11,
        TK_QINVOKE  = 4'd12,
        TK_QINDEX   = 4'd13,
        TK_NULLCOAL = 4'd14,
        TK_COLON    = 4'd15
    } t_tok_kind;

    // Kinds of entries held on the stack.
    typedef enum logic [2:0] {
        ENT_BRK0     = 3'd1,
        ENT_BRK1     = 3'd2,
        ENT_BRK2     = 3'd3,
        ENT_QUESTION = 3'd4,
        ENT_QINVOKE  = 3'd5,
        ENT_QINDEX   = 3'd6
    } t_ent_kind;

    // Verdict given to every token.
    typedef enum logic [2:0] {
        V_CONT     = 3'd0,
        V_SPLIT    = 3'd1,
        V_ERR_STOP = 3'd2,
        V_ERR_CONT = 3'd3,
        V_IGNORED  = 3'd4,
        V_OVERFLOW = 3'd5
    } t_verdict;

    // One token request as held in the input register.
    typedef struct packed {
        logic                  first_token;
        logic [MASK_BITS-1:0]  split_mask;
        logic [POS_BITS-1:0]   expr_start;
        logic [POS_BITS-1:0]   expr_end;
        t_tok_kind             token_kind;
        logic [POS_BITS-1:0]   token_start;
        logic [POS_BITS-1:0]   token_end;
    } t_tok_req;

    // One result request as held in the output register.
    typedef struct packed {
        t_verdict              verdict;
        t_tok_kind             split_kind;
        logic [POS_BITS-1:0]   left_start;
        logic [POS_BITS-1:0]   left_end;
        logic [POS_BITS-1:0]   right_start;
        logic [POS_BITS-1:0]   right_end;
    } t_res_req;

endpackage

`default_nettype wire

// ----- sv/tlds_if.sv -----
// ============================================================================
// Delimiter splitter channels
// Valid/ready channels for token requests and result requests.
// ============================================================================
`default_nettype none

// Token channel: one classified token per request.
interface tlds_tok_if;
    logic                            valid;
    logic                            ready;
    logic                            first_token;
    logic [tlds_pkg::MASK_BITS-1:0]  split_mask;
    logic [tlds_pkg::POS_BITS-1:0]   expr_start;
    logic [tlds_pkg::POS_BITS-1:0]   expr_end;
    logic [3:0]                      token_kind;
    logic [tlds_pkg::POS_BITS-1:0]   token_start;
    logic [tlds_pkg::POS_BITS-1:0]   token_end;

    modport source (
        output valid, first_token, split_mask, expr_start, expr_end,
               token_kind, token_start, token_end,
        input  ready
    );
    modport sink (
        input  valid, first_token, split_mask, expr_start, expr_end,
               token_kind, token_start, token_end,
        output ready
    );
endinterface

// Result channel: one verdict per token.
interface tlds_res_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      verdict;
    logic [3:0]                      split_kind;
    logic [tlds_pkg::POS_BITS-1:0]   left_start;
    logic [tlds_pkg::POS_BITS-1:0]   left_end;
    logic [tlds_pkg::POS_BITS-1:0]   right_start;
    logic [tlds_pkg::POS_BITS-1:0]   right_end;

    modport source (
        output valid, verdict, split_kind, left_start, left_end,
               right_start, right_end,
        input  ready
    );
    modport sink (
        input  valid, verdict, split_kind, left_start, left_end,
               right_start, right_end,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/top_level_delimiter_splitter_top.sv -----
// ============================================================================
// Top-level delimiter splitter
// Bracket-matching stack that gives one verdict per token and reports the
// spans of the left and right parts when a top-level split is found.
// ============================================================================
//
//  Channel   Dir  Handshake     Contents
//  i_tok     in   valid/ready   first_token, split_mask, expr span, token kind/span
//  o_res     out  valid/ready   verdict, split_kind, left span, right span
//
//  A token request passes through the input register and then the result
//  register, which drives o_res. One token is taken every cycle while o_res
//  does not stall; the stack top is read and pushed or popped in the same
//  cycle that the token leaves the input register.
//  Reset clears the stack level and marks the scan as ended; the stack
//  entries themselves are not cleared. While o_res stalls, one more token is
//  held in the input register before i_tok.ready drops.
//
`default_nettype none

module top_level_delimiter_splitter_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    tlds_tok_if.sink      i_tok,
    tlds_res_if.source    o_res
);

    // Input register and result register.
    logic                              r_in_valid;
    tlds_pkg::t_tok_req                r_in;
    logic                              r_out_valid;
    tlds_pkg::t_res_req                r_out;

    // Stack storage and scan state.
    tlds_pkg::t_ent_kind               r_stk_kind  [tlds_pkg::STACK_DEPTH];
    logic [tlds_pkg::POS_BITS-1:0]     r_stk_start [tlds_pkg::STACK_DEPTH];
    logic [tlds_pkg::POS_BITS-1:0]     r_stk_end   [tlds_pkg::STACK_DEPTH];
    logic [tlds_pkg::LEVEL_BITS-1:0]   r_level;
    logic                              r_ended;

    // Next-state values.
    logic [tlds_pkg::LEVEL_BITS-1:0]   n_level;
    logic                              n_ended;
    tlds_pkg::t_res_req                n_out;
    logic                              n_push;
    tlds_pkg::t_ent_kind               n_push_kind;

    // Internal combinational signals.
    logic                              w_advance;
    logic                              w_fire;
    logic                              w_in_accept;
    logic [tlds_pkg::LEVEL_BITS-1:0]   w_level;
    logic                              w_ended;
    logic                              w_empty;
    logic                              w_full;
    logic [tlds_pkg::IDX_BITS-1:0]     w_top_idx;
    logic [tlds_pkg::IDX_BITS-1:0]     w_push_idx;
    tlds_pkg::t_ent_kind               w_top_kind;
    logic [tlds_pkg::POS_BITS-1:0]     w_top_start;
    logic [tlds_pkg::POS_BITS-1:0]     w_top_end;
    logic                              w_match;
    logic                              w_mask_bit;

    // Handshake: the result register frees up when it is empty or taken.
    assign w_advance   = !r_out_valid || o_res.ready;
    assign w_fire      = r_in_valid && w_advance;
    assign i_tok.ready = !r_in_valid || w_advance;
    assign w_in_accept = i_tok.valid && i_tok.ready;

    // A first token restarts the scan before it is handled.
    assign w_level = r_in.first_token ? '0 : r_level;
    assign w_ended = r_in.first_token ? 1'b0 : r_ended;
    assign w_empty = (w_level == '0);
    assign w_full  = (w_level == tlds_pkg::LEVEL_BITS'(tlds_pkg::STACK_DEPTH));

    // Top of stack and push slot.
    assign w_top_idx   = tlds_pkg::IDX_BITS'(w_level - tlds_pkg::LEVEL_BITS'(1));
    assign w_push_idx  = w_level[tlds_pkg::IDX_BITS-1:0];
    assign w_top_kind  = r_stk_kind[w_top_idx];
    assign w_top_start = r_stk_start[w_top_idx];
    assign w_top_end   = r_stk_end[w_top_idx];

    // Opener match and split enable for the current token.
    always_comb begin
        w_match    = 1'b0;
        w_mask_bit = 1'b0;
        unique case (r_in.token_kind) inside
            tlds_pkg::TK_CLOSE0: begin
                w_match    = (w_top_kind == tlds_pkg::ENT_BRK0) ||
                             (w_top_kind == tlds_pkg::ENT_QINVOKE);
                w_mask_bit = r_in.split_mask[tlds_pkg::MASK_BRK0];
            end
            tlds_pkg::TK_CLOSE1: begin
                w_match    = (w_top_kind == tlds_pkg::ENT_BRK1) ||
                             (w_top_kind == tlds_pkg::ENT_QINDEX);
                w_mask_bit = r_in.split_mask[tlds_pkg::MASK_BRK1];
            end
            tlds_pkg::TK_CLOSE2: begin
                w_match    = (w_top_kind == tlds_pkg::ENT_BRK2);
                w_mask_bit = r_in.split_mask[tlds_pkg::MASK_BRK2];
            end
            tlds_pkg::TK_COMMA:    w_mask_bit = r_in.split_mask[tlds_pkg::MASK_COMMA];
            tlds_pkg::TK_SEMI:     w_mask_bit = r_in.split_mask[tlds_pkg::MASK_SEMI];
            tlds_pkg::TK_ASSIGN:   w_mask_bit = r_in.split_mask[tlds_pkg::MASK_ASSIGN];
            tlds_pkg::TK_LAMBDA:   w_mask_bit = r_in.split_mask[tlds_pkg::MASK_LAMBDA];
            tlds_pkg::TK_QUESTION: w_mask_bit = r_in.split_mask[tlds_pkg::MASK_QUESTION];
            tlds_pkg::TK_NULLCOAL: w_mask_bit = r_in.split_mask[tlds_pkg::MASK_NULLCOAL];
            tlds_pkg::TK_COLON:    w_mask_bit = r_in.split_mask[tlds_pkg::MASK_COLON];
            default: begin
                w_match    = 1'b0;
                w_mask_bit = 1'b0;
            end
        endcase
    end

    // Verdict and stack update for the token in the input register.
    always_comb begin
        n_level     = w_level;
        n_ended     = w_ended;
        n_push      = 1'b0;
        n_push_kind = tlds_pkg::ENT_BRK0;
        n_out       = '0;
        n_out.verdict    = tlds_pkg::V_CONT;
        n_out.split_kind = tlds_pkg::TK_OTHER;

        if (w_ended) begin
            n_out.verdict = tlds_pkg::V_IGNORED;
        end else begin
            unique case (r_in.token_kind) inside
                tlds_pkg::TK_OPEN0, tlds_pkg::TK_OPEN1, tlds_pkg::TK_OPEN2,
                tlds_pkg::TK_QINVOKE, tlds_pkg::TK_QINDEX: begin
                    case (r_in.token_kind)
                        tlds_pkg::TK_OPEN0:   n_push_kind = tlds_pkg::ENT_BRK0;
                        tlds_pkg::TK_OPEN1:   n_push_kind = tlds_pkg::ENT_BRK1;
                        tlds_pkg::TK_OPEN2:   n_push_kind = tlds_pkg::ENT_BRK2;
                        tlds_pkg::TK_QINVOKE: n_push_kind = tlds_pkg::ENT_QINVOKE;
                        default:              n_push_kind = tlds_pkg::ENT_QINDEX;
                    endcase
                    if (w_full) begin
                        n_out.verdict = tlds_pkg::V_OVERFLOW;
                        n_ended       = 1'b1;
                    end else begin
                        n_push  = 1'b1;
                        n_level = w_level + tlds_pkg::LEVEL_BITS'(1);
                    end
                end
                tlds_pkg::TK_CLOSE0, tlds_pkg::TK_CLOSE1, tlds_pkg::TK_CLOSE2: begin
                    n_out.right_start = r_in.token_start;
                    n_out.right_end   = r_in.token_end;
                    if (w_empty) begin
                        // Closing bracket with nothing open.
                        n_out.verdict = tlds_pkg::V_ERR_STOP;
                        n_ended       = 1'b1;
                    end else begin
                        n_level = w_level - tlds_pkg::LEVEL_BITS'(1);
                        if (!w_match) begin
                            n_out.verdict    = tlds_pkg::V_ERR_STOP;
                            n_out.left_start = w_top_start;
                            n_out.left_end   = w_top_end;
                            n_ended          = 1'b1;
                        end else if (w_level == tlds_pkg::LEVEL_BITS'(1) && w_mask_bit) begin
                            n_out.verdict    = tlds_pkg::V_SPLIT;
                            n_out.split_kind = r_in.token_kind;
                            n_out.left_start = w_top_start;
                            n_out.left_end   = w_top_end;
                            n_ended          = 1'b1;
                        end else begin
                            // Matched pair inside the expression: keep scanning.
                            n_out.right_start = '0;
                            n_out.right_end   = '0;
                        end
                    end
                end
                tlds_pkg::TK_COLON: begin
                    if (!w_empty) begin
                        // Inside brackets the colon closes a pending question.
                        n_level = w_level - tlds_pkg::LEVEL_BITS'(1);
                        if (w_top_kind != tlds_pkg::ENT_QUESTION) begin
                            n_out.verdict     = tlds_pkg::V_ERR_CONT;
                            n_out.right_start = r_in.token_start;
                            n_out.right_end   = r_in.token_end;
                        end
                    end else if (w_mask_bit) begin
                        n_out.verdict     = tlds_pkg::V_SPLIT;
                        n_out.split_kind  = r_in.token_kind;
                        n_out.left_start  = r_in.expr_start;
                        n_out.left_end    = r_in.token_start;
                        n_out.right_start = r_in.token_end;
                        n_out.right_end   = r_in.expr_end;
                        n_ended           = 1'b1;
                    end else begin
                        n_out.verdict     = tlds_pkg::V_ERR_CONT;
                        n_out.right_start = r_in.token_start;
                        n_out.right_end   = r_in.token_end;
                    end
                end
                tlds_pkg::TK_COMMA, tlds_pkg::TK_SEMI, tlds_pkg::TK_ASSIGN,
                tlds_pkg::TK_LAMBDA, tlds_pkg::TK_QUESTION, tlds_pkg::TK_NULLCOAL: begin
                    if (w_empty && w_mask_bit) begin
                        n_out.verdict     = tlds_pkg::V_SPLIT;
                        n_out.split_kind  = r_in.token_kind;
                        n_out.left_start  = r_in.expr_start;
                        n_out.left_end    = r_in.token_start;
                        n_out.right_start = r_in.token_end;
                        n_out.right_end   = r_in.expr_end;
                        n_ended           = 1'b1;
                    end else if (r_in.token_kind == tlds_pkg::TK_QUESTION) begin
                        // A question that does not split waits for its colon.
                        n_push_kind = tlds_pkg::ENT_QUESTION;
                        if (w_full) begin
                            n_out.verdict = tlds_pkg::V_OVERFLOW;
                            n_ended       = 1'b1;
                        end else begin
                            n_push  = 1'b1;
                            n_level = w_level + tlds_pkg::LEVEL_BITS'(1);
                        end
                    end
                end
                default: begin
                    n_level = w_level;
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tok.ready) begin
            r_in_valid <= i_tok.valid;
        end
        if (w_in_accept) begin
            r_in.first_token <= i_tok.first_token;
            r_in.split_mask  <= i_tok.split_mask;
            r_in.expr_start  <= i_tok.expr_start;
            r_in.expr_end    <= i_tok.expr_end;
            r_in.token_kind  <= tlds_pkg::t_tok_kind'(i_tok.token_kind);
            r_in.token_start <= i_tok.token_start;
            r_in.token_end   <= i_tok.token_end;
        end
    end

    // Scan state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_ended <= 1'b1;
        end else if (w_fire) begin
            r_level <= n_level;
            r_ended <= n_ended;
        end
    end

    // Stack entries: written only on a push.
    always_ff @(posedge i_clk) begin
        if (w_fire && n_push) begin
            r_stk_kind[w_push_idx]  <= n_push_kind;
            r_stk_start[w_push_idx] <= r_in.token_start;
            r_stk_end[w_push_idx]   <= r_in.token_end;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.verdict     = r_out.verdict;
    assign o_res.split_kind  = r_out.split_kind;
    assign o_res.left_start  = r_out.left_start;
    assign o_res.left_end    = r_out.left_end;
    assign o_res.right_start = r_out.right_start;
    assign o_res.right_end   = r_out.right_end;

    // The stack never holds more entries than it has room for.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= tlds_pkg::LEVEL_BITS'(tlds_pkg::STACK_DEPTH))
        else $error("stack level beyond depth");

    // A split, a stopping error or an overflow ends the scan.
    a_stop_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (n_out.verdict == tlds_pkg::V_SPLIT ||
                   n_out.verdict == tlds_pkg::V_ERR_STOP ||
                   n_out.verdict == tlds_pkg::V_OVERFLOW) |=> r_ended)
        else $error("scan not ended after a stopping verdict");

    // An ignored token leaves the stack untouched.
    a_ignored_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && n_out.verdict == tlds_pkg::V_IGNORED |=> $stable(r_level) && r_ended)
        else $error("ignored token changed the scan state");

    // A token only pushes while the scan is running and the stack has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && n_push |-> !w_full && !w_ended)
        else $error("push into a full stack or an ended scan");

endmodule

`default_nettype wire
